[hw/rtl/sdsi_pkg.sv]
// Package for the sorted set insert unit: word layouts, operation and status codes,
// and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package sdsi_pkg;

    // Operation codes carried in the input word.
    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_READ   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR  = 2'd2;

    // Status codes carried in the output word.
    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_PRESENT  = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_READ_OK  = 3'd3;
    localparam logic [2:0] ST_READ_BAD = 3'd4;
    localparam logic [2:0] ST_CLEARED  = 3'd5;

    // Input word.
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] value;
        logic [5:0]  index;
    } t_in_word;

    // Output word.
    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  position;
        logic [6:0]  element_count;
        logic [15:0] read_value;
    } t_out_word;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take;        // latch the input word
        logic       srch_init;   // open the search window over all entries
        logic       probe;       // read the entry at the window midpoint
        logic       narrow;      // shrink the window after a compare
        logic       shift_init;  // start moving entries from the top
        logic       shift_rd;    // read the entry below the move pointer
        logic       shift_wr;    // write it one place up, step the pointer down
        logic       place;       // write the new value, grow the count
        logic       rd_issue;    // read the entry at the requested index
        logic       clear;       // empty the set
        logic       res_load;    // capture a result with res_status
        logic [2:0] res_status;
        logic       emit;        // move the captured result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] func;        // operation of the latched word
        logic       lo_lt_hi;    // search window not empty
        logic       equal;       // probed entry equals the value
        logic       full;        // set holds its capacity
        logic       cnt_gt_lo;   // entries above the insert point must move
        logic       k_dec_gt_lo; // more entries remain to move after this one
        logic       idx_ok;      // read index lies below the count
        logic       out_free;    // output register can take a result
    } t_stat;

endpackage

`default_nettype wire

[hw/rtl/sdsi_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module sdsi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[hw/rtl/sdsi_ctrl.sv]
// Controller state machine of the sorted set insert unit.
// Depends on sdsi_pkg for the command and status bundles and the codes.
`default_nettype none

module sdsi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire sdsi_pkg::t_stat i_stat,
    output sdsi_pkg::t_cmd     o_cmd
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_PROBE     = 4'd2;
    localparam logic [3:0] S_COMPARE   = 4'd3;
    localparam logic [3:0] S_DECIDE    = 4'd4;
    localparam logic [3:0] S_SHIFT_RD  = 4'd5;
    localparam logic [3:0] S_SHIFT_WR  = 4'd6;
    localparam logic [3:0] S_PLACE     = 4'd7;
    localparam logic [3:0] S_READ_DATA = 4'd8;
    localparam logic [3:0] S_DONE      = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    // A word is taken only while no operation is in progress.
    assign o_stall = (r_state != S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (i_stat.func)
                    sdsi_pkg::FUNC_INSERT: begin
                        o_cmd.srch_init = 1'b1;
                        n_state         = S_PROBE;
                    end
                    sdsi_pkg::FUNC_READ: begin
                        if (i_stat.idx_ok) begin
                            o_cmd.rd_issue = 1'b1;
                            n_state        = S_READ_DATA;
                        end else begin
                            o_cmd.res_load   = 1'b1;
                            o_cmd.res_status = sdsi_pkg::ST_READ_BAD;
                            n_state          = S_DONE;
                        end
                    end
                    sdsi_pkg::FUNC_CLEAR: begin
                        o_cmd.clear      = 1'b1;
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = sdsi_pkg::ST_CLEARED;
                        n_state          = S_DONE;
                    end
                    default: begin
                        // The unused code changes nothing and answers nothing.
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_PROBE: begin
                if (i_stat.lo_lt_hi) begin
                    o_cmd.probe = 1'b1;
                    n_state     = S_COMPARE;
                end else begin
                    n_state = S_DECIDE;
                end
            end
            S_COMPARE: begin
                if (i_stat.equal) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = sdsi_pkg::ST_PRESENT;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.narrow = 1'b1;
                    n_state      = S_PROBE;
                end
            end
            S_DECIDE: begin
                if (i_stat.full) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = sdsi_pkg::ST_FULL;
                    n_state          = S_DONE;
                end else if (i_stat.cnt_gt_lo) begin
                    o_cmd.shift_init = 1'b1;
                    n_state          = S_SHIFT_RD;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_SHIFT_RD: begin
                o_cmd.shift_rd = 1'b1;
                n_state        = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_cmd.shift_wr = 1'b1;
                n_state        = i_stat.k_dec_gt_lo ? S_SHIFT_RD : S_PLACE;
            end
            S_PLACE: begin
                o_cmd.place      = 1'b1;
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = sdsi_pkg::ST_INSERTED;
                n_state          = S_DONE;
            end
            S_READ_DATA: begin
                o_cmd.res_load   = 1'b1;
                o_cmd.res_status = sdsi_pkg::ST_READ_OK;
                n_state          = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/sdsi_dpath.sv]
// Datapath of the sorted set insert unit: entry RAM, search window, move pointer,
// entry count, result capture and output register.
// Depends on sdsi_pkg and sdsi_ram.
`default_nettype none

module sdsi_dpath #(
    parameter int SET_CAPACITY = 64,
    parameter int VALUE_WIDTH  = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire sdsi_pkg::t_in_word  i_word,
    input  wire sdsi_pkg::t_cmd      i_cmd,
    output sdsi_pkg::t_stat          o_stat,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output sdsi_pkg::t_out_word      o_word
);

    localparam int AW = $clog2(SET_CAPACITY);
    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int XW = (CW > 6) ? CW : 6;

    // Latched operation.
    logic [1:0]             r_func;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [5:0]             r_idx;

    // Search window, move pointer and count.
    logic [CW-1:0] r_lo;
    logic [CW-1:0] r_hi;
    logic [CW-1:0] r_k;
    logic [CW-1:0] r_count;

    // Captured result and output register.
    logic [2:0]            r_status;
    logic [CW-1:0]         r_pos;
    logic [VALUE_WIDTH-1:0] r_rdv;
    logic                  r_out_valid;
    sdsi_pkg::t_out_word   r_out;

    logic [31:0]            in_val32;
    logic [CW-1:0]          mid;
    logic [CW-1:0]          k_dec;
    logic [XW-1:0]          idx_x;
    logic [XW-1:0]          cnt_x;
    logic [VALUE_WIDTH-1:0] rdata;
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [VALUE_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [31:0]            pos32;
    logic [31:0]            cnt32;
    logic [31:0]            rdv32;

    // Value narrowed or widened to the stored width.
    assign in_val32 = 32'(i_word.value);

    // Midpoint of the search window and the move pointer one step down.
    assign mid   = r_lo + ((r_hi - r_lo) >> 1);
    assign k_dec = r_k - CW'(1);
    assign idx_x = XW'(r_idx);
    assign cnt_x = XW'(r_count);

    // Status toward the controller.
    always_comb begin
        o_stat.func        = r_func;
        o_stat.lo_lt_hi    = (r_lo < r_hi);
        o_stat.equal       = (rdata == r_val);
        o_stat.full        = (r_count >= CW'(SET_CAPACITY));
        o_stat.cnt_gt_lo   = (r_count > r_lo);
        o_stat.k_dec_gt_lo = (k_dec > r_lo);
        o_stat.idx_ok      = (idx_x < cnt_x);
        o_stat.out_free    = !r_out_valid || !i_stall;
    end

    // RAM port selection: one read and one write per cycle.
    assign ram_we    = i_cmd.place || i_cmd.shift_wr;
    assign ram_waddr = i_cmd.place ? r_lo[AW-1:0] : r_k[AW-1:0];
    assign ram_wdata = i_cmd.place ? r_val : rdata;

    always_comb begin
        if (i_cmd.shift_rd) begin
            ram_raddr = k_dec[AW-1:0];
        end else if (i_cmd.rd_issue) begin
            ram_raddr = idx_x[AW-1:0];
        end else begin
            ram_raddr = mid[AW-1:0];
        end
    end

    sdsi_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (SET_CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    // Operation latch, search window and move pointer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func <= i_word.func;
            r_val  <= in_val32[VALUE_WIDTH-1:0];
            r_idx  <= i_word.index;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_count;
        end else if (i_cmd.narrow) begin
            if (rdata < r_val) begin
                r_lo <= mid + CW'(1);
            end else begin
                r_hi <= mid;
            end
        end
        if (i_cmd.shift_init) begin
            r_k <= r_count;
        end else if (i_cmd.shift_wr) begin
            r_k <= k_dec;
        end
    end

    // Entry count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear) begin
            r_count <= '0;
        end else if (i_cmd.place) begin
            r_count <= r_count + CW'(1);
        end
    end

    // Result capture; position and read value depend on the outcome.
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_status;
            case (i_cmd.res_status)
                sdsi_pkg::ST_PRESENT: begin
                    r_pos <= mid;
                    r_rdv <= '0;
                end
                sdsi_pkg::ST_INSERTED, sdsi_pkg::ST_FULL: begin
                    r_pos <= r_lo;
                    r_rdv <= '0;
                end
                sdsi_pkg::ST_READ_OK: begin
                    r_pos <= idx_x[CW-1:0];
                    r_rdv <= rdata;
                end
                default: begin
                    r_pos <= '0;
                    r_rdv <= '0;
                end
            endcase
        end
    end

    // Output word fields cut to their port widths.
    assign pos32 = 32'(r_pos);
    assign cnt32 = 32'(r_count);
    assign rdv32 = 32'(r_rdv);

    // Output register: holds a word until the receiver takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_out.status        <= r_status;
            r_out.position      <= pos32[6:0];
            r_out.element_count <= cnt32[6:0];
            r_out.read_value    <= rdv32[15:0];
        end
    end

    assign o_valid = r_out_valid;
    assign o_word  = r_out;

endmodule

`default_nettype wire

[hw/rtl/sorted_dedup_set_insert_unit.sv]
// Sorted set insert unit: keeps up to SET_CAPACITY distinct values in ascending order
// in one RAM with a registered read port, and takes one word at a time. An insert runs
// a binary search, each probe a read and then a compare, with at most about log2 of the
// count plus one probes, then moves each larger entry up by one place (read, then
// write) and writes the value. A value that is already present ends the search at the
// probe that finds it. A read out of range answers without a RAM read. An insert into
// a full set is dropped and flagged, a read at or past the count reports out of range.
// The result sits in an output register, so the next word is accepted while the
// previous result waits to be taken; the result of that next word then waits until the
// output register is free.
// Depends on sdsi_pkg, sdsi_ctrl and sdsi_dpath.
`default_nettype none

module sorted_dedup_set_insert_unit #(
    parameter int SET_CAPACITY = 64,
    parameter int VALUE_WIDTH  = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire sdsi_pkg::t_in_word  i_word,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output sdsi_pkg::t_out_word      o_word
);

    sdsi_pkg::t_cmd  cmd;
    sdsi_pkg::t_stat stat;

    // Sequencer.
    sdsi_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Storage and arithmetic.
    sdsi_dpath #(
        .SET_CAPACITY (SET_CAPACITY),
        .VALUE_WIDTH  (VALUE_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (i_word),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

endmodule

`default_nettype wire

[bench/sorted_dedup_set_insert_unit_test.sv]
// Testbench for the sorted set insert unit: drives insert, read, clear and unused words
// and checks every result word against a built-in model of the sorted set.
// Depends on sdsi_pkg and sorted_dedup_set_insert_unit.
`timescale 1ns / 100ps

module sorted_dedup_set_insert_unit_test;

    localparam int          CAPACITY      = 64;
    localparam logic [1:0]  FUNC_UNUSED   = 2'd3;
    localparam int          WORD_TARGET   = 750;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          IDLE_LIMIT    = 3000;
    localparam int          DRAIN_CYCLES  = 200;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    sdsi_pkg::t_in_word  i_word = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    sdsi_pkg::t_out_word o_word;

    // Model of the set: entries in ascending order and the number held.
    logic [15:0] held_values [CAPACITY];
    int unsigned held_count = 0;

    // Result words predicted but not yet seen at the output.
    sdsi_pkg::t_out_word pending_results [$];

    int          mismatch_count = 0;
    int          words_sent = 0;
    int          burst_left = 1;
    bit          hold_req = 1'b0;
    int          idle_cycles = 0;

    sorted_dedup_set_insert_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_word  (i_word),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_word  (o_word)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic sdsi_pkg::t_in_word make_word(input logic [1:0] func,
                                                     input logic [15:0] value,
                                                     input logic [5:0] index);
        sdsi_pkg::t_in_word w;
        w.func  = func;
        w.value = value;
        w.index = index;
        return w;
    endfunction

    function automatic bit value_held(input logic [15:0] v);
        for (int i = 0; i < held_count; i++) begin
            if (held_values[i] == v) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Apply one accepted word to the model and queue the result word it causes.
    task automatic apply_set_op(input sdsi_pkg::t_in_word w);
        sdsi_pkg::t_out_word res;
        int unsigned         lo;
        int unsigned         hi;
        int unsigned         mid;
        bit                  found;
        res   = '0;
        lo    = 0;
        hi    = held_count;
        mid   = 0;
        found = 1'b0;
        case (w.func)
            sdsi_pkg::FUNC_INSERT: begin
                // Binary search over the held entries.
                while (lo < hi && !found) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (held_values[mid] == w.value) begin
                        found = 1'b1;
                    end else if (held_values[mid] < w.value) begin
                        lo = mid + 1;
                    end else begin
                        hi = mid;
                    end
                end
                if (found) begin
                    res.status   = sdsi_pkg::ST_PRESENT;
                    res.position = 7'(mid);
                end else if (held_count >= CAPACITY) begin
                    res.status   = sdsi_pkg::ST_FULL;
                    res.position = 7'(lo);
                end else begin
                    // Move the larger entries up and place the value.
                    for (int k = held_count; k > lo; k--) begin
                        held_values[k] = held_values[k - 1];
                    end
                    held_values[lo] = w.value;
                    held_count++;
                    res.status   = sdsi_pkg::ST_INSERTED;
                    res.position = 7'(lo);
                end
                res.element_count = 7'(held_count);
                pending_results.push_back(res);
            end
            sdsi_pkg::FUNC_READ: begin
                if (w.index < held_count) begin
                    res.status     = sdsi_pkg::ST_READ_OK;
                    res.position   = 7'(w.index);
                    res.read_value = held_values[w.index];
                end else begin
                    res.status = sdsi_pkg::ST_READ_BAD;
                end
                res.element_count = 7'(held_count);
                pending_results.push_back(res);
            end
            sdsi_pkg::FUNC_CLEAR: begin
                held_count = 0;
                res.status = sdsi_pkg::ST_CLEARED;
                pending_results.push_back(res);
            end
            default: begin
                // The unused operation code leaves the set alone and answers nothing.
            end
        endcase
    endtask

    // Offer one word until it is taken, then maybe pause between bursts.
    task automatic send_word(input sdsi_pkg::t_in_word w);
        int gap;
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        apply_set_op(w);
        if (w.func != FUNC_UNUSED) words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [5:0] pick_read_index();
        if (held_count > 0 && $urandom_range(0, 9) < 8) begin
            return 6'($urandom_range(0, held_count - 1));
        end
        return 6'($urandom_range(0, CAPACITY - 1));
    endfunction

    // Extremes of the value range, duplicates, reads in and out of range, unused code, clear.
    task automatic test_directed();
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'hFFFF, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h0000, 6'd63));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h8000, 6'd63));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h0000, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'hFFFF, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h0000, 6'd21));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'hFFFF, 6'd42));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h8000, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h7FFF, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h8001, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h5555, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'hAAAA, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h1234, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h0000, 6'd7));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h0000, 6'd8));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'hFFFF, 6'd63));
        send_word(make_word(FUNC_UNUSED, 16'hFFFF, 6'd63));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h0000, 6'd3));
        send_word(make_word(sdsi_pkg::FUNC_CLEAR, 16'hFFFF, 6'd63));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h0000, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h1234, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'h0000, 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_CLEAR, 16'h0000, 6'd0));
    endtask

    // Fill the set to capacity, then probe it with present and absent values and reads.
    task automatic test_full_set(input bit narrow);
        logic [15:0] v;
        send_word(make_word(sdsi_pkg::FUNC_CLEAR, 16'($urandom), 6'($urandom)));
        while (held_count < CAPACITY) begin
            v = narrow ? 16'($urandom_range(0, 95)) : 16'($urandom);
            send_word(make_word(sdsi_pkg::FUNC_INSERT, v, 6'($urandom)));
        end
        // Values at both ends go to position zero or past the last entry.
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'h0000, 6'($urandom)));
        send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'hFFFF, 6'($urandom)));
        repeat (6) begin
            send_word(make_word(sdsi_pkg::FUNC_INSERT,
                                held_values[$urandom_range(0, CAPACITY - 1)],
                                6'($urandom)));
            do v = narrow ? 16'($urandom_range(0, 127)) : 16'($urandom);
            while (value_held(v));
            send_word(make_word(sdsi_pkg::FUNC_INSERT, v, 6'($urandom)));
        end
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'($urandom), 6'd0));
        send_word(make_word(sdsi_pkg::FUNC_READ, 16'($urandom), 6'd63));
        repeat (8) send_word(make_word(sdsi_pkg::FUNC_READ, 16'($urandom), 6'($urandom)));
        send_word(make_word(sdsi_pkg::FUNC_CLEAR, 16'($urandom), 6'($urandom)));
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_long_hold_off();
        hold_req = 1'b1;
        repeat (24) begin
            if ($urandom_range(0, 2) == 0) begin
                send_word(make_word(sdsi_pkg::FUNC_READ, 16'($urandom), pick_read_index()));
            end else begin
                send_word(make_word(sdsi_pkg::FUNC_INSERT, 16'($urandom), 6'($urandom)));
            end
        end
        // Stop offering so the last word is not taken a second time while draining.
        i_valid <= 1'b0;
        wait (!hold_req);
        wait_drained();
    endtask

    // Episodes of mixed operations, each with its own flavor of values.
    task automatic test_random_mix();
        int          episode_len;
        int          value_mode;
        int          pick;
        logic [15:0] v;
        logic [15:0] base;
        while (words_sent < WORD_TARGET) begin
            episode_len = $urandom_range(8, 48);
            value_mode  = $urandom_range(0, 2);
            base        = 16'($urandom);
            if ($urandom_range(0, 3) == 0) begin
                send_word(make_word(sdsi_pkg::FUNC_CLEAR, 16'($urandom), 6'($urandom)));
            end
            repeat (episode_len) begin
                pick = $urandom_range(0, 99);
                case (value_mode)
                    0: v = 16'($urandom);
                    1: v = base + 16'($urandom_range(0, 31));
                    default: begin
                        if (held_count > 0 && $urandom_range(0, 1) == 0) begin
                            v = held_values[$urandom_range(0, held_count - 1)]
                                + 16'($urandom_range(0, 2)) - 16'd1;
                        end else begin
                            v = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 7))
                                                            : 16'($urandom_range(65528, 65535));
                        end
                    end
                endcase
                if (pick < 58) begin
                    send_word(make_word(sdsi_pkg::FUNC_INSERT, v, 6'($urandom)));
                end else if (pick < 88) begin
                    send_word(make_word(sdsi_pkg::FUNC_READ, v, pick_read_index()));
                end else if (pick < 94) begin
                    send_word(make_word(FUNC_UNUSED, v, 6'($urandom)));
                end else begin
                    send_word(make_word(sdsi_pkg::FUNC_CLEAR, v, 6'($urandom)));
                end
            end
        end
    endtask

    // Receiver stall pattern, with a long hold-off whenever one is requested.
    initial begin
        int stall_mode;
        int mode_left;
        int phase;
        stall_mode = 0;
        mode_left  = 0;
        phase      = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall  <= 1'b0;
                hold_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(16, 200);
                end
                mode_left--;
                phase++;
                case (stall_mode)
                    0:       i_stall <= 1'b0;
                    1:       i_stall <= ($urandom_range(0, 3) == 0);
                    2:       i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= ((phase % 5) < 2);
                endcase
            end
        end
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge i_clk) begin
        sdsi_pkg::t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting: %p", o_word);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_word.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_word.status);
                    mismatch_count++;
                end
                if (o_word.position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, o_word.position);
                    mismatch_count++;
                end
                if (o_word.element_count !== want.element_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, o_word.element_count);
                    mismatch_count++;
                end
                if (o_word.read_value !== want.read_value) begin
                    $error("read_value: expected %0h, got %0h",
                           want.read_value, o_word.read_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves a word for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence.
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        held_count = 0;
        @(posedge i_clk);
        test_directed();
        test_full_set(1'b1);
        test_long_hold_off();
        test_full_set(1'b0);
        test_random_mix();
        i_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
